[rtl/core/zci_pkg.sv]
// Package for the zero-crossing interpolator: request types, sizes and
// helper functions. No dependencies.
`default_nettype none

package zci_pkg;

    localparam int MAX_SAMPLES    = 4096;
    localparam int IDX_W          = 13;   // sample counter, holds MAX_SAMPLES itself
    localparam int DIV_STEPS      = 17;   // quotient bits
    localparam int DIV_CNT_W      = 5;
    localparam logic [15:0] SPACING_RESET = 16'd4096;

    typedef struct packed {
        logic signed [15:0] sample_value;
        logic               frame_end;
    } zci_in_t;

    typedef struct packed {
        logic        kink_valid;
        logic [11:0] kink_index;
        logic [16:0] kink_fraction;
        logic [31:0] kink_position;
        logic [12:0] kink_number;
        logic        wrap_kink;
        logic        frame_done;
    } zci_out_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;      // take input request, update frame state
        logic div_start;   // load divider operands
        logic start_wrap;  // operands of the wrap pair (else the neighbor pair)
        logic div_step;    // one quotient bit
        logic load_kink;   // push crossing result
        logic sel_wrap;    // result being pushed is the wrap crossing
        logic load_sum;    // push empty summary
    } zci_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic pair_hit;
        logic wrap_hit;
        logic last;
        logic div_done;
        logic out_free;
    } zci_stat_t;

    function automatic logic crosses(input logic signed [15:0] u1,
                                     input logic signed [15:0] u2);
        return ((u2 <= 16'sd0) && (u1 > 16'sd0)) || ((u2 >= 16'sd0) && (u1 < 16'sd0));
    endfunction

    // |u| as unsigned; -32768 maps to 32768
    function automatic logic [15:0] mag(input logic signed [15:0] u);
        return u[15] ? (~u + 16'd1) : u;
    endfunction

endpackage

`default_nettype wire

[rtl/core/zci_ctrl.sv]
// Controller for the zero-crossing interpolator: sequences accept, divide,
// scale and result push. Depends on zci_pkg.
`default_nettype none

module zci_ctrl
    import zci_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire zci_stat_t stat,
    output zci_cmd_t       cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DISP = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_SUM  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       sel_reg, sel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sel_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        cmd        = '0;
        cmd.sel_wrap = sel_reg;
        in_stall   = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                priority if (stat.pair_hit)
                begin
                    cmd.div_start  = 1'b1;
                    cmd.start_wrap = 1'b0;
                    sel_next       = 1'b0;
                    state_next     = S_DIV;
                end
                else if (stat.wrap_hit)
                begin
                    cmd.div_start  = 1'b1;
                    cmd.start_wrap = 1'b1;
                    sel_next       = 1'b1;
                    state_next     = S_DIV;
                end
                else if (stat.last)
                    state_next = S_SUM;
                else
                    state_next = S_IDLE;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done)
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                if (stat.out_free)
                begin
                    cmd.load_kink = 1'b1;
                    if (!sel_reg && stat.wrap_hit)
                    begin
                        cmd.div_start  = 1'b1;
                        cmd.start_wrap = 1'b1;
                        sel_next       = 1'b1;
                        state_next     = S_DIV;
                    end
                    else
                        state_next = S_IDLE;
                end
            end
            S_SUM:
            begin
                if (stat.out_free)
                begin
                    cmd.load_sum = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_div_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) && stat.div_done |=> (state_reg == S_MUL))
        else $error("divider finished but no scale step followed");
    a_sum_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SUM) |-> stat.last)
        else $error("summary outside frame end");
`endif

endmodule

`default_nettype wire

[rtl/core/zci_datapath.sv]
// Datapath of the zero-crossing interpolator: frame state, crossing check,
// radix-2 divider, position scaling and output register. Depends on zci_pkg.
`default_nettype none

module zci_datapath
    import zci_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire zci_in_t     in_data,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_data,
    input  wire zci_cmd_t    cmd,
    output zci_stat_t        stat,
    output logic             out_valid,
    input  wire logic        out_stall,
    output zci_out_t         out_data
);

    // frame state
    logic [15:0]            spacing_reg;
    logic signed [15:0]     prev_reg, first_reg;
    logic [IDX_W-1:0]       index_reg, count_reg;

    // pending job from the last accepted request
    logic                   pair_reg, wrap_reg, last_reg;
    logic [15:0]            pm1_reg, pm2_reg, wm1_reg, wm2_reg;
    logic [11:0]            pidx_reg, widx_reg;
    logic [IDX_W-1:0]       pnum_reg, wnum_reg, snum_reg;

    // divider
    logic [17:0]            r_reg;
    logic [16:0]            den_reg, q_reg;
    logic [DIV_CNT_W-1:0]   cnt_reg;

    logic                   out_valid_reg;
    zci_out_t               out_reg;

    // ---- crossing check on the incoming sample
    logic                   act, pair_c, wrap_c, last_c;
    logic signed [15:0]     prev_new, first_new;
    logic [IDX_W-1:0]       index_new, idx_m1, idx_new_m1;

    always_comb
    begin
        last_c     = in_data.frame_end;
        act        = index_reg < IDX_W'(MAX_SAMPLES);
        pair_c     = act && (index_reg != '0) && crosses(prev_reg, in_data.sample_value);
        prev_new   = act ? in_data.sample_value : prev_reg;
        first_new  = (act && (index_reg == '0)) ? in_data.sample_value : first_reg;
        index_new  = act ? index_reg + IDX_W'(1) : index_reg;
        wrap_c     = last_c && (index_new != '0) && crosses(prev_new, first_new);
        idx_m1     = index_reg - IDX_W'(1);
        idx_new_m1 = index_new - IDX_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spacing_reg <= SPACING_RESET;
            prev_reg    <= '0;
            first_reg   <= '0;
            index_reg   <= '0;
            count_reg   <= '0;
            pair_reg    <= 1'b0;
            wrap_reg    <= 1'b0;
            last_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                spacing_reg <= cfg_data;
            if (cmd.accept)
            begin
                prev_reg  <= prev_new;
                first_reg <= first_new;
                pair_reg  <= pair_c;
                wrap_reg  <= wrap_c;
                last_reg  <= last_c;
                if (last_c)
                begin
                    index_reg <= '0;
                    count_reg <= '0;
                end
                else
                begin
                    index_reg <= index_new;
                    count_reg <= count_reg + IDX_W'(pair_c);
                end
            end
        end
    end

    // job payload, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            pm1_reg  <= mag(prev_reg);
            pm2_reg  <= mag(in_data.sample_value);
            wm1_reg  <= mag(prev_new);
            wm2_reg  <= mag(first_new);
            pidx_reg <= idx_m1[11:0];
            widx_reg <= idx_new_m1[11:0];
            pnum_reg <= count_reg + IDX_W'(1);
            wnum_reg <= count_reg + IDX_W'(pair_c) + IDX_W'(1);
            snum_reg <= count_reg;
        end
    end

    // ---- restoring divider: floor(m1 * 2^16 / (m1 + m2)), one bit a cycle
    logic        ge;
    logic [17:0] diff, rem;
    logic [15:0] sm1, sm2;

    always_comb
    begin
        sm1  = cmd.start_wrap ? wm1_reg : pm1_reg;
        sm2  = cmd.start_wrap ? wm2_reg : pm2_reg;
        ge   = r_reg >= {1'b0, den_reg};
        diff = r_reg - {1'b0, den_reg};
        rem  = ge ? diff : r_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (cmd.div_start)
            cnt_reg <= '0;
        else if (cmd.div_step)
            cnt_reg <= cnt_reg + DIV_CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            r_reg   <= {2'b00, sm1};
            den_reg <= {1'b0, sm1} + {1'b0, sm2};
            q_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            r_reg <= {rem[16:0], 1'b0};
            q_reg <= {q_reg[15:0], ge};
        end
    end

    // ---- position scaling, straight into the output register
    logic [11:0] kidx;
    logic [28:0] base;
    logic [44:0] prod;

    always_comb
    begin
        kidx = cmd.sel_wrap ? widx_reg : pidx_reg;
        base = {1'b0, kidx, 16'd0} + {12'd0, q_reg};
        prod = base * spacing_reg;
    end

    logic out_free;
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_kink || cmd.load_sum)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_kink)
        begin
            out_reg.kink_valid    <= 1'b1;
            out_reg.kink_index    <= kidx;
            out_reg.kink_fraction <= q_reg;
            out_reg.kink_position <= prod[43:12];
            out_reg.kink_number   <= cmd.sel_wrap ? wnum_reg : pnum_reg;
            out_reg.wrap_kink     <= cmd.sel_wrap;
            out_reg.frame_done    <= cmd.sel_wrap || (last_reg && !wrap_reg);
        end
        else if (cmd.load_sum)
        begin
            out_reg.kink_valid    <= 1'b0;
            out_reg.kink_index    <= '0;
            out_reg.kink_fraction <= '0;
            out_reg.kink_position <= '0;
            out_reg.kink_number   <= snum_reg;
            out_reg.wrap_kink     <= 1'b0;
            out_reg.frame_done    <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        stat.pair_hit = pair_reg;
        stat.wrap_hit = wrap_reg;
        stat.last     = last_reg;
        stat.div_done = cnt_reg == DIV_CNT_W'(DIV_STEPS - 1);
        stat.out_free = out_free;
    end

`ifndef SYNTHESIS
    a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        index_reg <= IDX_W'(MAX_SAMPLES))
        else $error("sample index past frame limit");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= index_reg)
        else $error("more crossings than samples");
    a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> (cnt_reg < DIV_CNT_W'(DIV_STEPS)))
        else $error("divider stepped too often");
    a_frac_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_kink |-> (q_reg <= 17'd65536))
        else $error("fraction above one step");
`endif

endmodule

`default_nettype wire

[rtl/core/zero_crossing_interpolator_core.sv]
// Top level of the zero-crossing interpolator: joins controller and datapath.
// Depends on zci_pkg, zci_ctrl, zci_datapath.
`default_nettype none

// Usage:
//  - Input channel (in_valid/in_stall/in_data): one signed Q1.14 sample per
//    request, frame_end set on the frame's last sample. A request is taken
//    when in_valid is high and in_stall low.
//  - Output channel (out_valid/out_stall/out_data): zero, one or two results
//    per input request. Each crossing carries index, 17-bit fraction,
//    position (Q16.16 after spacing scale) and the running crossing count;
//    the frame's last result has frame_done set. A frame end without any
//    crossing gives one summary result with kink_valid low.
//  - cfg_we/cfg_data write sample_spacing (Q4.12); write only while idle.
//  - Sequence: a sample without a crossing is accepted, then dispatched; a
//    frame end without a crossing adds a summary push. Each crossing adds
//    the radix-2 divider steps computing u1/(u1-u2), one quotient bit per
//    step, plus a scale/output step; in_stall stays high meanwhile.
//  - Reset (rst_n, async) clears frame state, spacing returns to 1.0.
//  - A stalled receiver holds the output register; the block waits in its
//    output step and keeps in_stall high until the result can be loaded.
module zero_crossing_interpolator_core
    import zci_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire zci_in_t     in_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output zci_out_t         out_data,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_data
);

    zci_cmd_t  cmd;
    zci_stat_t stat;

    zci_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    zci_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

[sim/tb_zero_crossing_interpolator_core.sv]
// Self-checking testbench for zero_crossing_interpolator_core: sample frames in, every
// crossing and summary result predicted in the bench and compared field by field.
// Depends on zci_pkg and the core RTL.
module tb_zero_crossing_interpolator_core;
    import zci_pkg::*;

    localparam int CLK_HALF         = 4;
    localparam int RESET_CYCLES     = 8;
    localparam int CYCLE_LIMIT      = 2_000_000;
    localparam int DRAIN_CYCLES     = 40;
    localparam int RANDOM_PER_PHASE = 500;
    localparam int MODEL            = -1;         // row is checked by the predictor
    localparam zci_out_t NO_KINK    = '0;

    // One request on the input channel. n_typed is the number of hand-written
    // results (0 or 1) or MODEL when the predictor supplies them.
    typedef struct {
        zci_in_t  req;
        int       n_typed;
        zci_out_t typed;
    } sample_req_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    zci_in_t     in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    zci_out_t    out_data;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_data = '0;

    sample_req_t send_q[$];     // requests not yet on the bus
    sample_req_t on_bus;        // request currently offered
    zci_out_t    kink_q[$];     // results still owed by the block
    int          send_idle_pct = 18;
    int          stall_pct = 46;
    int          errors = 0;
    int          cycles = 0;

    // Predictor copy of the frame state and the spacing register.
    logic [15:0]        spacing_q;
    logic signed [15:0] prev_smp;
    logic signed [15:0] first_smp;
    int                 smp_cnt;
    int                 kink_cnt;

    sample_req_t directed_tab[22];

    zero_crossing_interpolator_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Sign change between neighbors: positive to non-positive, or negative
    // to non-negative. A zero first sample never starts a crossing.
    function automatic bit sign_flip(logic signed [15:0] u1, logic signed [15:0] u2);
        return (u1 > 0 && u2 <= 0) || (u1 < 0 && u2 >= 0);
    endfunction

    // Crossing result; kink_cnt must already include this crossing.
    function automatic zci_out_t make_kink(int idx, logic signed [15:0] u1,
                                           logic signed [15:0] u2, bit wrap);
        longint   m1;
        longint   m2;
        longint   frac;
        longint   pos;
        longint   sp;
        zci_out_t k;
        m1   = (u1 < 0) ? -longint'(u1) : longint'(u1);
        m2   = (u2 < 0) ? -longint'(u2) : longint'(u2);
        sp   = spacing_q;
        frac = (m1 << 16) / (m1 + m2);          // u2 == 0 gives a full step
        pos  = (((longint'(idx) << 16) + frac) * sp) >> 12;
        k.kink_valid    = 1'b1;
        k.kink_index    = idx[11:0];
        k.kink_fraction = frac[16:0];
        k.kink_position = pos[31:0];
        k.kink_number   = kink_cnt[12:0];
        k.wrap_kink     = wrap;
        k.frame_done    = 1'b0;
        return k;
    endfunction

    // Advance the predicted frame state by one accepted request; returns the
    // number of results (1 or 2 on a frame end, 0 or 1 otherwise).
    function automatic int predict_sample(zci_in_t req, output zci_out_t res[2]);
        int       n;
        zci_out_t summ;
        n = 0;
        // Samples past MAX_SAMPLES are dropped, but their frame_end still counts.
        if (smp_cnt < MAX_SAMPLES)
        begin
            if (smp_cnt == 0)
                first_smp = req.sample_value;
            else if (sign_flip(prev_smp, req.sample_value))
            begin
                kink_cnt++;
                res[n] = make_kink(smp_cnt - 1, prev_smp, req.sample_value, 1'b0);
                n++;
            end
            prev_smp = req.sample_value;
            smp_cnt++;
        end
        if (req.frame_end)
        begin
            // Periodic wrap: last accepted sample against the first one.
            if (smp_cnt != 0 && sign_flip(prev_smp, first_smp))
            begin
                kink_cnt++;
                res[n] = make_kink(smp_cnt - 1, prev_smp, first_smp, 1'b1);
                n++;
            end
            if (n == 0)
            begin
                summ             = '0;
                summ.kink_number = kink_cnt[12:0];
                summ.frame_done  = 1'b1;
                res[0]           = summ;
                n                = 1;
            end
            else
                res[n-1].frame_done = 1'b1;
            smp_cnt  = 0;
            kink_cnt = 0;
        end
        return n;
    endfunction

    task automatic compare_field(string name, longint unsigned want, longint unsigned got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    task automatic check_kink(zci_out_t got);
        zci_out_t want;
        if (kink_q.size() == 0)
        begin
            errors++;
            $display("%0t: result with none expected, actual %h", $time, got);
        end
        else
        begin
            want = kink_q.pop_front();
            compare_field("kink_valid", want.kink_valid, got.kink_valid);
            compare_field("kink_index", want.kink_index, got.kink_index);
            compare_field("kink_fraction", want.kink_fraction, got.kink_fraction);
            compare_field("kink_position", want.kink_position, got.kink_position);
            compare_field("kink_number", want.kink_number, got.kink_number);
            compare_field("wrap_kink", want.wrap_kink, got.wrap_kink);
            compare_field("frame_done", want.frame_done, got.frame_done);
        end
    endtask

    // Request driver. Values read here are the ones from before the edge, so
    // acceptance is judged on what the block saw. in_valid gets exactly one
    // nonblocking write per edge when it may change.
    always @(posedge clk)
    begin : drive_requests
        zci_out_t res[2];
        int       n;
        if (in_valid && !in_stall)
        begin
            n = predict_sample(on_bus.req, res);
            if (on_bus.n_typed == MODEL)
            begin
                for (int i = 0; i < n; i++)
                    kink_q.push_back(res[i]);
            end
            else if (on_bus.n_typed == 1)
                kink_q.push_back(on_bus.typed);
        end
        // Payload only moves when the bus is empty or the request was just taken.
        if (!in_valid || !in_stall)
        begin
            if (send_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                on_bus   = send_q.pop_front();
                in_data  <= on_bus.req;
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Result receiver with random back-pressure.
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            check_kink(out_data);
        out_stall <= rst_n && ($urandom_range(99) < stall_pct);
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Block until every request is taken and every result has come back, then
    // let a request without a result run out of the pipe.
    task automatic wait_idle();
        while (send_q.size() != 0 || in_valid || kink_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write sample_spacing; only called while the block is idle.
    task automatic set_spacing(logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_data  <= value;
        spacing_q = value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Whole frames with random content. Styles: raw noise, alternating sign,
    // smooth random walk (the usual periodic field), and edge values.
    task automatic random_frames(int n_items);
        int          left;
        int          len;
        int          style;
        int          v;
        int          walk;
        sample_req_t r;
        left = n_items;
        while (left > 0)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40);
            if (len > left)
                len = left;
            style = $urandom_range(3);
            walk  = $urandom_range(65535) - 32768;
            for (int i = 0; i < len; i++)
            begin
                case (style)
                    0: v = $urandom_range(65535) - 32768;
                    1: v = (i % 2) ? -int'($urandom_range(1, 32768)) : $urandom_range(0, 32767);
                    2:
                    begin
                        walk = walk + $urandom_range(12000) - 6000;
                        if (walk > 32767)
                            walk = 32767;
                        if (walk < -32768)
                            walk = -32768;
                        v = walk;
                    end
                    default:
                        case ($urandom_range(5))
                            0: v = -32768;
                            1: v = 32767;
                            2: v = 0;
                            3: v = 1;
                            4: v = -1;
                            default: v = $urandom_range(6) - 3;
                        endcase
                endcase
                r.req.sample_value = 16'(v);
                r.req.frame_end    = (i == len - 1);
                r.n_typed          = MODEL;
                r.typed            = NO_KINK;
                send_q.push_back(r);
            end
            left -= len;
        end
    endtask

    initial
    begin : run
        spacing_q = SPACING_RESET;
        prev_smp  = '0;
        first_smp = '0;
        smp_cnt   = 0;
        kink_cnt  = 0;

        // Directed frames at the reset spacing (1.0, so position = idx.frac).
        directed_tab = '{
            // one-sample frame: wrap against itself, empty summary
            '{'{16'sd100, 1'b1}, 1, '{1'b0, 12'd0, 17'd0, 32'd0, 13'd0, 1'b0, 1'b1}},
            // half-step crossings, second one closes the frame
            '{'{16'sd16384, 1'b0}, 0, NO_KINK},
            '{'{-16'sd16384, 1'b0}, 1, '{1'b1, 12'd0, 17'd32768, 32'd32768, 13'd1, 1'b0, 1'b0}},
            '{'{16'sd16384, 1'b1}, 1, '{1'b1, 12'd1, 17'd32768, 32'd98304, 13'd2, 1'b0, 1'b1}},
            // full-scale swing, landing on zero, zero start, pair plus wrap
            '{'{16'sd32767, 1'b0}, 0, NO_KINK},
            '{'{-16'sd32768, 1'b0}, MODEL, NO_KINK},
            '{'{16'sd0, 1'b0}, 1, '{1'b1, 12'd1, 17'd65536, 32'd131072, 13'd2, 1'b0, 1'b0}},
            '{'{16'sd32767, 1'b0}, 0, NO_KINK},
            '{'{-16'sd1, 1'b1}, MODEL, NO_KINK},
            // all-zero frame
            '{'{16'sd0, 1'b0}, 0, NO_KINK},
            '{'{16'sd0, 1'b0}, 0, NO_KINK},
            '{'{16'sd0, 1'b1}, 1, '{1'b0, 12'd0, 17'd0, 32'd0, 13'd0, 1'b0, 1'b1}},
            // two-sample frame: pair crossing and wrap crossing on one request
            '{'{16'sd100, 1'b0}, 0, NO_KINK},
            '{'{-16'sd100, 1'b1}, MODEL, NO_KINK},
            // negative to positive, through zero, wrap back
            '{'{-16'sd1, 1'b0}, 0, NO_KINK},
            '{'{16'sd1, 1'b0}, 1, '{1'b1, 12'd0, 17'd32768, 32'd32768, 13'd1, 1'b0, 1'b0}},
            '{'{16'sd0, 1'b0}, MODEL, NO_KINK},
            '{'{16'sd5, 1'b1}, MODEL, NO_KINK},
            // most negative to most positive and back by the wrap
            '{'{-16'sd32768, 1'b0}, 0, NO_KINK},
            '{'{16'sd32767, 1'b1}, MODEL, NO_KINK},
            // single-sample frames at the extremes
            '{'{-16'sd32768, 1'b1}, 1, '{1'b0, 12'd0, 17'd0, 32'd0, 13'd0, 1'b0, 1'b1}},
            '{'{16'sd0, 1'b1}, 1, '{1'b0, 12'd0, 17'd0, 32'd0, 13'd0, 1'b0, 1'b1}}
        };

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Sender idles 18%, receiver stalls 46%.
        foreach (directed_tab[i])
            send_q.push_back(directed_tab[i]);
        wait_idle();

        set_spacing(16'd0);
        random_frames(RANDOM_PER_PHASE);
        wait_idle();

        // Swap the idle rates.
        send_idle_pct = 46;
        stall_pct     = 18;
        set_spacing(16'hFFFF);
        random_frames(RANDOM_PER_PHASE);
        wait_idle();

        // Full rate on both sides.
        send_idle_pct = 0;
        stall_pct     = 0;
        set_spacing(16'($urandom_range(1, 65534)));
        random_frames(RANDOM_PER_PHASE);
        wait_idle();

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/zci_pkg.sv
rtl/core/zci_ctrl.sv
rtl/core/zci_datapath.sv
rtl/core/zero_crossing_interpolator_core.sv
sim/tb_zero_crossing_interpolator_core.sv
